[design/codeword_stream_packer_assert.svh]
// Assertion macros shared by the codeword stream packer modules
`ifndef CODEWORD_STREAM_PACKER_ASSERT_SVH
`define CODEWORD_STREAM_PACKER_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define CWSP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another at the next clock edge
`define CWSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/cwsp_pkg.sv]
// Package with group record type and byte kind codes for the codeword stream packer
package cwsp_pkg;

  localparam int GROUP_SIZE  = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] KIND_REP = 2'd0;
  localparam logic [1:0] KIND_HI  = 2'd1;
  localparam logic [1:0] KIND_CW  = 2'd2;

  typedef struct packed {
    logic [GROUP_SIZE-1:0][7:0] lows;
    logic [GROUP_SIZE-1:0]      hi;
    logic [GROUP_SIZE-1:1]      rep;
    logic [2:0]                 last_idx;
    logic                       fend;
  } grp_t;

endpackage

[design/codeword_stream_packer.sv]
// Codeword stream packer: packs 9-bit codebook indices into a flagged byte stream
//
// Input channel: codeword and frame_end are taken at a clock edge with push high
// and full low. Eight codewords, or fewer when frame_end is set, form a group.
// Output channel: while empty is low the oldest byte sits on out_byte, byte_kind,
// group_last and frame_last; it is taken at an edge with pop high.
// Each closed group yields a repeat flag byte, a high flag byte when any codeword
// is 256 or more, and the low byte of each codeword that does not repeat the one
// before it. group_last marks a group's final byte, frame_last the final byte of
// a group closed by frame_end.
// Timing: with the back end idle, a group enters the queue at the edge that takes
// its closing codeword, and its first byte then goes from the queue head into the
// output register. The front end takes one codeword per cycle while the queue has
// room; the back end, which sets the sustained rate, emits one byte per cycle while
// the receiver takes them: 2 to 10 per group, about one per codeword plus up to two.
// A stalled receiver holds the output register; the back end then stops, the
// queue fills and full rises. Reset empties the queue and output and opens a
// fresh group.
module codeword_stream_packer #(
  parameter int QUEUE_DEPTH = cwsp_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [8:0] codeword,
  input  logic       frame_end,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [1:0] byte_kind,
  output logic       group_last,
  output logic       frame_last
);
  import cwsp_pkg::*;

  grp_t q_din;
  grp_t q_dout;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  logic out_valid;

  cwsp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .codeword  (codeword),
    .frame_end (frame_end),
    .full      (full),
    .q_push    (q_push),
    .q_din     (q_din),
    .q_full    (q_full)
  );

  cwsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid)
  );

  cwsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_dout),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_byte   (out_byte),
    .byte_kind  (byte_kind),
    .group_last (group_last),
    .frame_last (frame_last)
  );

  assign empty = !out_valid;

endmodule

[design/cwsp_front.sv]
// Front end: collects codewords into groups and classifies high and repeat codewords
module cwsp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic [8:0]     codeword,
  input  logic           frame_end,
  output logic           full,
  output logic           q_push,
  output cwsp_pkg::grp_t q_din,
  input  logic           q_full
);
  import cwsp_pkg::*;

  logic [2:0]                 fill;
  logic [8:0]                 prev;
  logic [GROUP_SIZE-1:0][7:0] lows;
  logic [GROUP_SIZE-1:0][7:0] lows_next;
  logic [GROUP_SIZE-1:0]      hi_acc;
  logic [GROUP_SIZE-1:0]      hi_next;
  logic [GROUP_SIZE-1:1]      rep_acc;
  logic [GROUP_SIZE-1:0]      rep_next;
  logic                       accept;
  logic                       closes;
  logic                       is_rep;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign closes = (fill == 3'(GROUP_SIZE - 1)) || frame_end;
  assign is_rep = (fill != 3'd0) && (codeword == prev);

  always_comb begin
    lows_next       = lows;
    lows_next[fill] = codeword[7:0];
    hi_next         = hi_acc | (GROUP_SIZE'(codeword[8]) << fill);
    rep_next        = {rep_acc, 1'b0} | (GROUP_SIZE'(is_rep) << fill);
  end

  always_comb begin
    q_din.lows     = lows_next;
    q_din.hi       = hi_next;
    q_din.rep      = rep_next[GROUP_SIZE-1:1];
    q_din.last_idx = fill;
    q_din.fend     = frame_end;
  end

  assign q_push = accept && closes;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      hi_acc  <= '0;
      rep_acc <= '0;
    end else if (accept) begin
      if (closes) begin
        fill    <= '0;
        hi_acc  <= '0;
        rep_acc <= '0;
      end else begin
        fill    <= fill + 3'd1;
        hi_acc  <= hi_next;
        rep_acc <= rep_next[GROUP_SIZE-1:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lows <= lows_next;
      prev <= codeword;
    end
  end

endmodule

[design/cwsp_queue.sv]
// Short queue of closed group records between front and back end
module cwsp_queue #(
  parameter int DEPTH = cwsp_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cwsp_pkg::grp_t din,
  output logic           full,
  input  logic           pop,
  output cwsp_pkg::grp_t dout,
  output logic           valid
);
  import cwsp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  grp_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] cnt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign valid   = (cnt != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

`include "codeword_stream_packer_assert.svh"

  `CWSP_ASSERT_ALWAYS(a_cnt_bound, cnt <= CW'(DEPTH), "queue count above depth")
  `CWSP_ASSERT_NEXT(a_push_fill, do_push && !do_pop, valid, "queue empty after push")

endmodule

[design/cwsp_back.sv]
// Back end: walks a group record and emits its bytes into the output register
module cwsp_back (
  input  logic           clk,
  input  logic           rst,
  input  cwsp_pkg::grp_t head,
  input  logic           q_valid,
  output logic           q_pop,
  input  logic           pop,
  output logic           out_valid,
  output logic [7:0]     out_byte,
  output logic [1:0]     byte_kind,
  output logic           group_last,
  output logic           frame_last
);
  import cwsp_pkg::*;

  typedef enum logic [2:0] {
    S_REP = 3'b001,
    S_HI  = 3'b010,
    S_CW  = 3'b100
  } bstate_t;

  bstate_t               state;
  bstate_t               state_next;
  logic [2:0]            idx;
  logic [2:0]            idx_next;
  logic                  take;
  logic                  hi_any;
  logic [GROUP_SIZE-1:0] emit_mask;
  logic                  nxt_found;
  logic [2:0]            nxt_idx;
  logic [7:0]            byte_sel;
  logic [1:0]            kind_sel;
  logic                  glast_sel;

  assign take      = q_valid && (!out_valid || pop);
  assign hi_any    = (head.hi != '0);
  assign emit_mask = {~head.rep, 1'b1};

  always_comb begin
    nxt_found = 1'b0;
    nxt_idx   = '0;
    for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
      if (emit_mask[k] && (3'(k) > idx) && (3'(k) <= head.last_idx)) begin
        nxt_found = 1'b1;
        nxt_idx   = 3'(k);
      end
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    byte_sel   = head.lows[idx];
    kind_sel   = KIND_CW;
    glast_sel  = 1'b0;
    q_pop      = 1'b0;
    unique case (state)
      S_REP: begin
        byte_sel = {head.rep, hi_any};
        kind_sel = KIND_REP;
        idx_next = '0;
        if (take) begin
          state_next = hi_any ? S_HI : S_CW;
        end
      end
      S_HI: begin
        byte_sel = head.hi;
        kind_sel = KIND_HI;
        idx_next = '0;
        if (take) begin
          state_next = S_CW;
        end
      end
      S_CW: begin
        glast_sel = !nxt_found;
        if (take) begin
          if (nxt_found) begin
            idx_next = nxt_idx;
          end else begin
            q_pop      = 1'b1;
            idx_next   = '0;
            state_next = S_REP;
          end
        end
      end
      default: begin
        state_next = S_REP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_REP;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (take) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte   <= byte_sel;
      byte_kind  <= kind_sel;
      group_last <= glast_sel;
      frame_last <= glast_sel && head.fend;
    end
  end

`include "codeword_stream_packer_assert.svh"

  `CWSP_ASSERT_ALWAYS(a_fl_gl, !out_valid || !frame_last || group_last, "frame end without group end")
  `CWSP_ASSERT_ALWAYS(a_hi_nz, !out_valid || byte_kind != KIND_HI || out_byte != 8'd0, "zero high flag byte")
  `CWSP_ASSERT_NEXT(a_rep_out, take && state == S_REP, out_valid && byte_kind == KIND_REP && !group_last, "repeat flag byte lost")

endmodule

[dv/cwsp_checker.sv]
// Checker that predicts the packed byte stream of the codeword stream packer and compares it
`timescale 1ns / 100ps

module cwsp_checker
  import cwsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [8:0]  codeword,
  input  logic        frame_end,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_byte,
  input  logic [1:0]  byte_kind,
  input  logic        group_last,
  input  logic        frame_last,
  output int unsigned error_count,
  output int unsigned pending_count
);

  typedef struct packed {
    logic [7:0] value;
    logic [1:0] kind;
    logic       glast;
    logic       flast;
  } stream_byte_t;

  stream_byte_t awaited_bytes[$];
  logic [8:0]   open_words [GROUP_SIZE];
  logic [2:0]   open_fill;
  int unsigned  fails = 0;

  assign error_count   = fails;
  assign pending_count = awaited_bytes.size();

  task automatic pack_group(input int unsigned count, input logic fend);
    logic [7:0]   hi_flags;
    logic [7:0]   rep_flags;
    stream_byte_t item;
    stream_byte_t grp_bytes[$];
    hi_flags  = '0;
    rep_flags = '0;
    for (int j = 0; j < count; j++) begin
      if (open_words[j] >= 9'd256) hi_flags[j] = 1'b1;
    end
    rep_flags[0] = |hi_flags;
    for (int j = 1; j < count; j++) begin
      if (open_words[j] == open_words[j-1]) rep_flags[j] = 1'b1;
    end
    grp_bytes.push_back('{value: rep_flags, kind: KIND_REP, glast: 1'b0, flast: 1'b0});
    if (hi_flags != 0) begin
      grp_bytes.push_back('{value: hi_flags, kind: KIND_HI, glast: 1'b0, flast: 1'b0});
    end
    for (int j = 0; j < count; j++) begin
      if (j == 0 || !rep_flags[j]) begin
        grp_bytes.push_back('{value: open_words[j][7:0], kind: KIND_CW,
                              glast: 1'b0, flast: 1'b0});
      end
    end
    item       = grp_bytes.pop_back();
    item.glast = 1'b1;
    item.flast = fend;
    grp_bytes.push_back(item);
    foreach (grp_bytes[k]) awaited_bytes.push_back(grp_bytes[k]);
  endtask

  always @(posedge clk) begin
    stream_byte_t want;
    if (rst) begin
      open_fill = '0;
      awaited_bytes.delete();
    end else begin
      if (push && !full) begin
        open_words[open_fill] = codeword;
        if (open_fill == 3'd7 || frame_end) begin
          pack_group(open_fill + 1, frame_end);
          open_fill = '0;
        end else begin
          open_fill = open_fill + 3'd1;
        end
      end
      if (pop && !empty) begin
        if (awaited_bytes.size() == 0) begin
          $error("unexpected transaction: out_byte %0h byte_kind %0d", out_byte, byte_kind);
          fails++;
        end else begin
          want = awaited_bytes.pop_front();
          if (out_byte !== want.value) begin
            $error("out_byte: expected %0h, actual %0h", want.value, out_byte);
            fails++;
          end
          if (byte_kind !== want.kind) begin
            $error("byte_kind: expected %0d, actual %0d", want.kind, byte_kind);
            fails++;
          end
          if (group_last !== want.glast) begin
            $error("group_last: expected %0b, actual %0b", want.glast, group_last);
            fails++;
          end
          if (frame_last !== want.flast) begin
            $error("frame_last: expected %0b, actual %0b", want.flast, frame_last);
            fails++;
          end
        end
      end
    end
  end

endmodule

[dv/testbench.sv]
// Top of the codeword stream packer testbench: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 100ps

module testbench;
  import cwsp_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 220;
  localparam int DRAIN_CYCLES = 20;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        push      = 1'b0;
  logic        pop       = 1'b0;
  logic [8:0]  codeword  = '0;
  logic        frame_end = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  out_byte;
  logic [1:0]  byte_kind;
  logic        group_last;
  logic        frame_last;
  logic        idling    = 1'b1;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned quiet_cycles = 0;

  always #10 clk = ~clk;

  codeword_stream_packer DUT (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .codeword   (codeword),
    .frame_end  (frame_end),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .byte_kind  (byte_kind),
    .group_last (group_last),
    .frame_last (frame_last)
  );

  cwsp_checker stream_check (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .codeword      (codeword),
    .frame_end     (frame_end),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .byte_kind     (byte_kind),
    .group_last    (group_last),
    .frame_last    (frame_last),
    .error_count   (mismatches),
    .pending_count (outstanding)
  );

  always @(negedge clk) begin
    pop <= idling ? ($urandom_range(99) >= 15) : 1'b1;
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Call at a falling edge; returns at the falling edge after the transaction.
  task automatic send_word(input logic [8:0] cw, input logic fe);
    while (idling && $urandom_range(99) < 15) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push      <= 1'b1;
    codeword  <= cw;
    frame_end <= fe;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [8:0]  mixed_words [8];
    int unsigned fill;
    logic [8:0]  prev;
    logic [8:0]  cw;
    logic        fe;
    logic        low_only;
    mixed_words = '{9'd0, 9'd511, 9'd256, 9'd255, 9'd255, 9'd1, 9'd170, 9'd85};
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 8; i++) send_word(mixed_words[i], 1'b0);
    for (int i = 0; i < 8; i++) send_word(9'd300, i == 7);
    send_word(9'd0, 1'b1);
    send_word(9'd7, 1'b0);
    send_word(9'd7, 1'b0);
    send_word(9'd400, 1'b1);
    send_word(9'd129, 1'b0);
    send_word(9'd129, 1'b1);

    fill     = 0;
    prev     = '0;
    low_only = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idling = !(i >= 80 && i < 140);
      if (fill > 0 && $urandom_range(99) < 30) begin
        cw = prev;
      end else begin
        cw = 9'($urandom_range(511));
        if (low_only) cw[8] = 1'b0;
      end
      fe = (i == RANDOM_ITEMS - 1) || ($urandom_range(99) < 8);
      send_word(cw, fe);
      prev = cw;
      if (fe || fill == 7) begin
        fill     = 0;
        low_only = ($urandom_range(3) == 0);
      end else begin
        fill++;
      end
    end
    push <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
